@@ src/seven_segment_mux_display_core_macros.svh @@
// Assertion macros shared by the display core.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_CORE_MACROS_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent in this cycle implies consequent in the same cycle
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/ssd_pkg.sv @@
package ssd_pkg;

    localparam int SEGMENTS = 8;
    localparam int DIGITS   = 2;
    localparam int DP_INDEX = 7;

    // command codes
    localparam logic [3:0] CMD_TICK         = 4'd0;
    localparam logic [3:0] CMD_SCAN         = 4'd1;
    localparam logic [3:0] CMD_CHAR         = 4'd2;
    localparam logic [3:0] CMD_BLINK_CHAR   = 4'd3;
    localparam logic [3:0] CMD_SET_POINT    = 4'd4;
    localparam logic [3:0] CMD_BLINK_POINT  = 4'd5;
    localparam logic [3:0] CMD_NUMBER       = 4'd6;
    localparam logic [3:0] CMD_BLINK_NUMBER = 4'd7;
    localparam logic [3:0] CMD_SIGNED       = 4'd8;

    // segment modes; code three is never written and reads as off
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BLINK_ON     = 2'd0;
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd1;
    localparam logic [1:0] REG_BACK_POINT   = 2'd2;
    localparam logic [1:0] REG_FWD_POINT    = 2'd3;

    localparam logic [11:0] BLINK_ON_RESET     = 12'd500;
    localparam logic [11:0] BLINK_PERIOD_RESET = 12'd1000;
    localparam logic [11:0] ELAPSED_MAX        = 12'hFFF;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [16:0] NUMBER_LIMIT = 17'd100;

    typedef struct packed {
        logic        [3:0]  cmd;
        logic        [1:0]  digit;
        logic        [7:0]  char_code;
        logic signed [15:0] number;
        logic               flag;
    } item_t;

    typedef struct packed {
        logic [1:0] anode_lines;
        logic [7:0] segment_lines;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    typedef struct packed {
        logic is_scan;
        logic out_blocked;
    } status_t;

    // {hit, segment mask 6..0}
    function automatic logic [7:0] glyph_lookup(input logic [7:0] code);
        unique case (code)
            8'h30:   return {1'b1, 7'h3F}; // '0'
            8'h31:   return {1'b1, 7'h30};
            8'h32:   return {1'b1, 7'h5B};
            8'h33:   return {1'b1, 7'h79};
            8'h34:   return {1'b1, 7'h74};
            8'h35:   return {1'b1, 7'h6D};
            8'h36:   return {1'b1, 7'h6F};
            8'h37:   return {1'b1, 7'h38};
            8'h38:   return {1'b1, 7'h7F};
            8'h39:   return {1'b1, 7'h7D}; // '9'
            8'h41:   return {1'b1, 7'h7E}; // 'A'
            8'h43:   return {1'b1, 7'h0F}; // 'C'
            8'h63:   return {1'b1, 7'h43}; // 'c'
            8'h45:   return {1'b1, 7'h4F}; // 'E'
            8'h46:   return {1'b1, 7'h4E}; // 'F'
            8'h6F:   return {1'b1, 7'h63}; // 'o'
            8'h2D:   return {1'b1, 7'h40}; // '-'
            8'h20:   return {1'b1, 7'h00}; // blank
            default: return 8'h00;
        endcase
    endfunction

endpackage

@@ src/ssd_controller.sv @@
module ssd_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  ssd_pkg::status_t status,
    output ssd_pkg::ctrl_t   ctrl
);
    import ssd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold a scan until the result register can take it
                if (!(status.is_scan && status.out_blocked))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        item_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall   = 1'b0;
                ctrl.capture = item_valid;
            end
            ST_EXEC:
            begin
                ctrl.execute = !(status.is_scan && status.out_blocked);
            end
            default: item_stall = 1'b1;
        endcase
    end

endmodule

@@ src/ssd_datapath.sv @@
module ssd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ssd_pkg::item_t   item,
    input  ssd_pkg::ctrl_t   ctrl,
    output ssd_pkg::status_t status,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [11:0]      cfg_data,
    output logic             result_valid,
    input  logic             result_stall,
    output ssd_pkg::result_t result
);
    import ssd_pkg::*;

    item_t       held_reg;
    logic [1:0]  modes_reg [DIGITS][SEGMENTS];
    logic [1:0]  modes_next [DIGITS][SEGMENTS];
    logic [11:0] elapsed_reg;
    logic [11:0] elapsed_next;
    logic [11:0] blink_on_reg;
    logic [11:0] blink_period_reg;
    logic        back_point_reg;
    logic        fwd_point_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        result_valid_reg;

    logic        digit_ok;
    logic        dsel;
    logic [7:0]  char_glyph;
    logic [16:0] value;
    logic        in_range;
    logic [6:0]  value_low;
    logic [13:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones_wide;
    logic [7:0]  tens_glyph;
    logic [7:0]  ones_glyph;
    logic [7:0]  hi_glyph;
    logic [7:0]  lo_glyph;
    logic [1:0]  lit_mode;
    logic        blink_lit;
    logic        is_number;

    assign digit_ok   = !held_reg.digit[1];
    assign dsel       = held_reg.digit[0];
    assign char_glyph = glyph_lookup(held_reg.char_code);

    // signed form takes the magnitude; -32768 becomes 32768 and shows dashes
    always_comb
    begin
        value = {held_reg.number[15], held_reg.number};
        if (held_reg.cmd == CMD_SIGNED && held_reg.number[15])
            value = 17'd0 - {held_reg.number[15], held_reg.number};
    end

    assign in_range   = !value[16] && (value < NUMBER_LIMIT);
    assign value_low  = value[6:0];
    // divide by ten via reciprocal, exact for values below 100
    assign tens_prod  = {7'd0, value_low} * 14'd103;
    assign tens       = tens_prod[13:10];
    assign ones_wide  = value_low - 7'({tens, 3'd0} + {2'd0, tens, 1'b0});
    assign tens_glyph = glyph_lookup(CHAR_ZERO + {4'd0, tens});
    assign ones_glyph = glyph_lookup(CHAR_ZERO + {4'd0, ones_wide[3:0]});
    assign hi_glyph   = in_range ? tens_glyph : glyph_lookup(CHAR_DASH);
    assign lo_glyph   = in_range ? ones_glyph : glyph_lookup(CHAR_DASH);

    assign is_number  = (held_reg.cmd == CMD_NUMBER) || (held_reg.cmd == CMD_BLINK_NUMBER)
                        || (held_reg.cmd == CMD_SIGNED);
    assign lit_mode   = (held_reg.cmd == CMD_BLINK_CHAR || held_reg.cmd == CMD_BLINK_NUMBER)
                        ? MODE_BLINK : MODE_ON;

    // blink window and timer update
    always_comb
    begin
        elapsed_next = elapsed_reg;
        blink_lit    = 1'b1;
        if (held_reg.cmd == CMD_TICK)
        begin
            if (elapsed_reg != ELAPSED_MAX)
                elapsed_next = elapsed_reg + 12'd1;
        end
        if (elapsed_reg <= blink_on_reg)
            blink_lit = 1'b1;
        else if (elapsed_reg <= blink_period_reg)
            blink_lit = 1'b0;
        else
        begin
            blink_lit = 1'b1;
            if (held_reg.cmd == CMD_SCAN)
                elapsed_next = 12'd0;
        end
    end

    always_comb
    begin
        modes_next = modes_reg;
        case (held_reg.cmd)
            CMD_CHAR, CMD_BLINK_CHAR:
            begin
                if (digit_ok && char_glyph[7])
                begin
                    for (int j = 0; j < 7; j++)
                        modes_next[dsel][j] = char_glyph[j] ? lit_mode : MODE_OFF;
                end
            end
            CMD_SET_POINT:
            begin
                if (digit_ok)
                    modes_next[dsel][DP_INDEX] = held_reg.flag ? MODE_ON : MODE_OFF;
            end
            CMD_BLINK_POINT:
            begin
                if (digit_ok)
                    modes_next[dsel][DP_INDEX] = MODE_BLINK;
            end
            default:
            begin
                if (is_number)
                begin
                    modes_next[back_point_reg][DP_INDEX] = MODE_OFF;
                    modes_next[fwd_point_reg][DP_INDEX]  = MODE_OFF;
                    for (int j = 0; j < 7; j++)
                    begin
                        modes_next[1][j] = hi_glyph[j] ? lit_mode : MODE_OFF;
                        modes_next[0][j] = lo_glyph[j] ? lit_mode : MODE_OFF;
                    end
                    if (held_reg.cmd == CMD_SIGNED)
                    begin
                        // forward write last, so it wins when both name one digit
                        modes_next[back_point_reg][DP_INDEX] =
                            held_reg.flag ? MODE_ON : MODE_OFF;
                        modes_next[fwd_point_reg][DP_INDEX] =
                            held_reg.flag ? MODE_OFF : MODE_ON;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        result_next.anode_lines   = 2'b11;
        result_next.segment_lines = 8'hFF;
        if (digit_ok)
        begin
            result_next.anode_lines = dsel ? 2'b01 : 2'b10;
            for (int j = 0; j < SEGMENTS; j++)
                result_next.segment_lines[j] = !((modes_reg[dsel][j] == MODE_ON)
                    || (modes_reg[dsel][j] == MODE_BLINK && blink_lit));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            held_reg <= item;
        if (ctrl.execute && held_reg.cmd == CMD_SCAN)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIGITS; d++)
                for (int j = 0; j < SEGMENTS; j++)
                    modes_reg[d][j] <= MODE_OFF;
            elapsed_reg      <= 12'd0;
            blink_on_reg     <= BLINK_ON_RESET;
            blink_period_reg <= BLINK_PERIOD_RESET;
            back_point_reg   <= 1'b1;
            fwd_point_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.execute)
            begin
                modes_reg   <= modes_next;
                elapsed_reg <= elapsed_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLINK_ON:     blink_on_reg     <= cfg_data;
                    REG_BLINK_PERIOD: blink_period_reg <= cfg_data;
                    REG_BACK_POINT:   back_point_reg   <= cfg_data[0];
                    REG_FWD_POINT:    fwd_point_reg    <= cfg_data[0];
                    default:          blink_on_reg     <= blink_on_reg;
                endcase
            end
            if (ctrl.execute && held_reg.cmd == CMD_SCAN)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign status.is_scan     = (held_reg.cmd == CMD_SCAN);
    assign status.out_blocked = result_valid_reg && result_stall;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

endmodule

@@ src/seven_segment_mux_display_core.sv @@
// Two-digit multiplexed seven-segment display core. Each command beat on the
// item channel is captured in the idle state and executed in the execute
// state; the core takes no new beat until the last one has executed. A scan
// waits in the execute state only while the result register still holds an
// untaken beat. A millisecond tick advances the saturating blink timer; a scan
// returns active-low anode and segment lines for one digit (digit 2 or 3 blanks
// all anodes) and may restart the timer. Char, point and number commands update
// the per-segment mode store (off, on, blink) and give no result. Write the
// configuration registers (blink on time, blink period, backward and forward
// point digits) only while the core is idle.
`include "seven_segment_mux_display_core_macros.svh"

module seven_segment_mux_display_core (
    input  logic             clk,
    input  logic             rst_n,
    // command beats
    input  logic             item_valid,
    output logic             item_stall,
    input  ssd_pkg::item_t   item,
    // scan results
    output logic             result_valid,
    input  logic             result_stall,
    output ssd_pkg::result_t result,
    // configuration writes
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [11:0]      cfg_data
);
    import ssd_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    // a scan retires in this cycle and loads the result register
    logic    scan_exec;

    assign scan_exec = ctrl.execute && status.is_scan;

    // sequence capture and execute
    ssd_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .ctrl       (ctrl)
    );

    // mode store, blink timer, glyph decode and result register
    ssd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctrl         (ctrl),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // an accepted beat moves the core out of idle
    `SSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)
    // never overwrite a result that is still stalled
    `SSD_ASSERT_SAME(a_no_overwrite, clk, rst_n, scan_exec, !status.out_blocked)
    // a new result comes only from an executed scan
    `SSD_ASSERT_SAME(a_result_source, clk, rst_n, $rose(result_valid), $past(scan_exec))

endmodule
